// ----- src/rrc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrc_pkg: shared constants, prototype rom and microprogram
// Holds the Q2.14 root-raised-cosine prototype, the tap placement function
// and the control store of the tap generator sequencer.
// ----------------------------------------------------------------------------
package rrc_pkg;

  localparam int MAX_HALF  = 32;
  localparam int TAP_BITS  = 16;
  localparam int HL_W      = 6;
  localparam int IDX_W     = 6;
  localparam int PROTO_W   = 16;
  localparam int MAG_W     = 15;
  localparam int SUM_W     = 24;
  localparam int DIV_W     = SUM_W - 1;
  localparam int FRAC      = TAP_BITS - 1;
  localparam int NUM_W     = MAG_W + FRAC + 1;
  localparam int RCP_K     = NUM_W;
  localparam int RCP_W     = RCP_K + 1;
  localparam int DCNT_W    = $clog2(RCP_W);
  localparam int PROD2_W   = TAP_BITS + DIV_W;
  localparam int REM_W     = ((NUM_W > PROD2_W) ? NUM_W : PROD2_W) + 1;
  localparam int ROM_LEN   = 17;
  localparam int ROM_IDX_W = $clog2(ROM_LEN);
  localparam int STEP_W    = 4;
  localparam int PROG_DEPTH = 2 ** STEP_W;

  // prototype taps, signed Q2.14, index is offset from center in half symbols
  localparam logic signed [PROTO_W-1:0] PROTO_ROM [ROM_LEN] = '{
    16'sd17167, 16'sd10311, -16'sd760,  -16'sd3129, 16'sd694,  16'sd1539,
    -16'sd592,  -16'sd788,  16'sd468,   16'sd355,   -16'sd335, -16'sd99,
    16'sd209,   -16'sd41,   -16'sd100,  16'sd100,   16'sd17
  };

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_ACC,
    OP_DSETUP,
    OP_DSTEP,
    OP_TSETUP,
    OP_FETCH,
    OP_MUL1,
    OP_MUL2,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    W_NONE,
    W_IN,
    W_OUT
  } wait_e;

  typedef enum logic [2:0] {
    J_NEVER,
    J_ALWAYS,
    J_NOT_END,
    J_NOT_DDONE,
    J_NOT_LAST
  } jmp_e;

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    op_e   op;
    wait_e wt;
    jmp_e  jc;
    step_t target;
  } ctrl_word_t;

  localparam step_t STEP_IDLE  = STEP_W'(0);
  localparam step_t STEP_SUM   = STEP_W'(1);
  localparam step_t STEP_DIV   = STEP_W'(3);
  localparam step_t STEP_FETCH = STEP_W'(5);

  // one word per step: wait condition stalls the step, jump overrides step + 1
  localparam ctrl_word_t PROGRAM [PROG_DEPTH] = '{
    '{OP_LOAD,   W_IN,   J_NEVER,     STEP_IDLE},
    '{OP_ACC,    W_NONE, J_NOT_END,   STEP_SUM},
    '{OP_DSETUP, W_NONE, J_NEVER,     STEP_IDLE},
    '{OP_DSTEP,  W_NONE, J_NOT_DDONE, STEP_DIV},
    '{OP_TSETUP, W_NONE, J_NEVER,     STEP_IDLE},
    '{OP_FETCH,  W_NONE, J_NEVER,     STEP_IDLE},
    '{OP_MUL1,   W_NONE, J_NEVER,     STEP_IDLE},
    '{OP_MUL2,   W_NONE, J_NEVER,     STEP_IDLE},
    '{OP_EMIT,   W_OUT,  J_NOT_LAST,  STEP_FETCH},
    '{OP_NOP,    W_NONE, J_ALWAYS,    STEP_IDLE},
    '{OP_NOP,    W_NONE, J_ALWAYS,    STEP_IDLE},
    '{OP_NOP,    W_NONE, J_ALWAYS,    STEP_IDLE},
    '{OP_NOP,    W_NONE, J_ALWAYS,    STEP_IDLE},
    '{OP_NOP,    W_NONE, J_ALWAYS,    STEP_IDLE},
    '{OP_NOP,    W_NONE, J_ALWAYS,    STEP_IDLE},
    '{OP_NOP,    W_NONE, J_ALWAYS,    STEP_IDLE}
  };

  // tap value at position idx of a filter with half length n
  // center c = n/2; left side mirrors about n - c, which puts the first
  // off-center value on the center for odd n
  function automatic logic signed [PROTO_W-1:0] rrc_tap(
    input logic [HL_W-1:0]  n,
    input logic [IDX_W-1:0] idx
  );
    logic [HL_W-1:0] c;
    logic [HL_W-1:0] d;
    logic [HL_W-1:0] k;
    c = n >> 1;
    d = n - c;
    k = '0;
    rrc_tap = '0;
    if (HL_W'(idx) <= n) begin
      k = (HL_W'(idx) <= c) ? (d - HL_W'(idx)) : (HL_W'(idx) - c);
      if (k < HL_W'(ROM_LEN)) begin
        rrc_tap = PROTO_ROM[k[ROM_IDX_W-1:0]];
      end
    end
  endfunction

endpackage

// ----- src/rrc_tap_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrc_tap_generator: normalized root-raised-cosine tap generator
// Microcoded sequencer that sums the prototype taps, forms a reciprocal of
// the sum and emits 2n normalized Q1.15 taps in index order.
// ----------------------------------------------------------------------------
// One input transfer carries a half length n (0 is taken as 1, values above
// 32 as 32) and yields 2n output transfers, tap_index 0 .. 2n-1, with
// last_tap set on the final one. Taps come from a Q2.14 prototype rom
// (roll-off 0.175, two samples per symbol) and are divided by their sum,
// rounded half away from zero and saturated to Q1.15. One run sums n + 1
// prototype taps, forms the reciprocal bit-serially, then takes four control
// steps per tap (fetch, two multiplies, round and emit). The result register
// lets the last tap wait while the next half length is already taken.
module rrc_tap_generator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [rrc_pkg::HL_W-1:0]         half_length_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [rrc_pkg::TAP_BITS-1:0] tap_value_o,
  output logic [rrc_pkg::IDX_W-1:0]        tap_index_o,
  output logic                             last_tap_o
);
  import rrc_pkg::*;

  // saturation limits in magnitude
  localparam logic [TAP_BITS:0] POS_LIM = {2'b00, {FRAC{1'b1}}};
  localparam logic [TAP_BITS:0] NEG_LIM = {2'b01, {FRAC{1'b0}}};

  // sequencer
  step_t      step_q, step_d;
  ctrl_word_t cw;
  logic       go;
  logic       jump;
  logic       out_free;

  // datapath registers
  logic [HL_W-1:0]         n_q, n_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [DIV_W-1:0]        div_q, div_d;
  logic [DIV_W-1:0]        rem_q, rem_d;
  logic [RCP_W-1:0]        rcp_q, rcp_d;
  logic [DCNT_W-1:0]       dcnt_q, dcnt_d;
  logic                    neg_q, neg_d;
  logic [NUM_W-1:0]        num_q, num_d;
  logic [NUM_W:0]          qe_q, qe_d;
  logic                    sat_q, sat_d;
  logic [PROD2_W-1:0]      prod2_q, prod2_d;

  // result register
  logic                       out_valid_q, out_valid_d;
  logic signed [TAP_BITS-1:0] tap_value_q, tap_value_d;
  logic [IDX_W-1:0]           tap_index_q, tap_index_d;
  logic                       last_tap_q, last_tap_d;

  // helpers
  logic signed [PROTO_W-1:0] tap;
  logic [PROTO_W-1:0]        tap_mag;
  logic [HL_W:0]             total;
  logic                      is_last;
  logic [DIV_W:0]            rsh;
  logic                      dvd_bit;
  logic [NUM_W+RCP_W-1:0]    prod1;
  logic [REM_W-1:0]          rmd;
  logic [TAP_BITS:0]         q_fix;
  logic [TAP_BITS:0]         q_sat;
  logic [TAP_BITS:0]         q_neg;

  assign cw       = PROGRAM[step_q];
  assign out_free = !out_valid_q || !out_stall_i;

  // input side is open only while the current step waits on it
  assign in_stall_o = (cw.wt != W_IN);

  assign total   = {n_q, 1'b0};
  assign is_last = ({1'b0, idx_q} == (total - (HL_W+1)'(1)));

  // wait and jump conditions
  always_comb begin
    unique case (cw.wt)
      W_NONE:  go = 1'b1;
      W_IN:    go = in_valid_i;
      W_OUT:   go = out_free;
      default: go = 1'b1;
    endcase
  end

  always_comb begin
    unique case (cw.jc)
      J_NEVER:     jump = 1'b0;
      J_ALWAYS:    jump = 1'b1;
      J_NOT_END:   jump = (HL_W'(idx_q) != n_q);
      J_NOT_DDONE: jump = (dcnt_q != '0);
      J_NOT_LAST:  jump = !is_last;
      default:     jump = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    step_d = step_q;
    if (go) begin
      step_d = jump ? cw.target : (step_q + STEP_W'(1));
    end
  end

  // tap lookup for the current index
  assign tap     = rrc_tap(n_q, idx_q);
  assign tap_mag = tap[PROTO_W-1] ? (PROTO_W'(0) - tap) : tap;

  // reciprocal divider step: dividend is 2^RCP_K, one quotient bit a cycle
  assign dvd_bit = (dcnt_q == DCNT_W'(RCP_K));
  assign rsh     = {rem_q, dvd_bit};

  // estimate is at most one below the true quotient
  assign prod1 = NUM_W'(num_q) * rcp_q;

  // remainder check and saturation
  always_comb begin
    rmd   = REM_W'(num_q) - REM_W'(prod2_q);
    q_fix = {1'b0, qe_q[TAP_BITS-1:0]}
            + ((rmd >= REM_W'(div_q)) ? (TAP_BITS+1)'(1) : (TAP_BITS+1)'(0));
    if (neg_q) begin
      q_sat = (sat_q || (q_fix > NEG_LIM)) ? NEG_LIM : q_fix;
    end else begin
      q_sat = (sat_q || (q_fix > POS_LIM)) ? POS_LIM : q_fix;
    end
    q_neg = (TAP_BITS+1)'(0) - q_sat;
  end

  // datapath micro-operations
  always_comb begin
    n_d         = n_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    div_d       = div_q;
    rem_d       = rem_q;
    rcp_d       = rcp_q;
    dcnt_d      = dcnt_q;
    neg_d       = neg_q;
    num_d       = num_q;
    qe_d        = qe_q;
    sat_d       = sat_q;
    prod2_d     = prod2_q;
    tap_value_d = tap_value_q;
    tap_index_d = tap_index_q;
    last_tap_d  = last_tap_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (go) begin
      unique case (cw.op)
        OP_NOP: begin
        end
        OP_LOAD: begin
          // clamp half length into 1 .. MAX_HALF
          if (half_length_i == '0) begin
            n_d = HL_W'(1);
          end else if (half_length_i > HL_W'(MAX_HALF)) begin
            n_d = HL_W'(MAX_HALF);
          end else begin
            n_d = half_length_i;
          end
          idx_d = '0;
          sum_d = '0;
        end
        OP_ACC: begin
          // only indices 0 .. n carry taps
          sum_d = sum_q + SUM_W'(tap);
          idx_d = idx_q + IDX_W'(1);
        end
        OP_DSETUP: begin
          // a non-positive sum divides by one
          if (!sum_q[SUM_W-1] && (sum_q != '0)) begin
            div_d = sum_q[DIV_W-1:0];
          end else begin
            div_d = DIV_W'(1);
          end
          rem_d  = '0;
          rcp_d  = '0;
          dcnt_d = DCNT_W'(RCP_K);
        end
        OP_DSTEP: begin
          if (rsh >= {1'b0, div_q}) begin
            rem_d = DIV_W'(rsh - {1'b0, div_q});
            rcp_d = {rcp_q[RCP_W-2:0], 1'b1};
          end else begin
            rem_d = rsh[DIV_W-1:0];
            rcp_d = {rcp_q[RCP_W-2:0], 1'b0};
          end
          dcnt_d = dcnt_q - DCNT_W'(1);
        end
        OP_TSETUP: begin
          idx_d = '0;
        end
        OP_FETCH: begin
          // numerator with half the divisor added for rounding
          neg_d = tap[PROTO_W-1];
          num_d = (NUM_W'(tap_mag[MAG_W-1:0]) << FRAC) + NUM_W'(div_q >> 1);
        end
        OP_MUL1: begin
          qe_d = prod1[RCP_K +: NUM_W+1];
        end
        OP_MUL2: begin
          sat_d   = |qe_q[NUM_W:TAP_BITS];
          prod2_d = PROD2_W'(qe_q[TAP_BITS-1:0]) * PROD2_W'(div_q);
        end
        OP_EMIT: begin
          out_valid_d = 1'b1;
          tap_value_d = neg_q ? q_neg[TAP_BITS-1:0] : q_sat[TAP_BITS-1:0];
          tap_index_d = idx_q;
          last_tap_d  = is_last;
          idx_d       = idx_q + IDX_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath and result payload
  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    idx_q       <= idx_d;
    sum_q       <= sum_d;
    div_q       <= div_d;
    rem_q       <= rem_d;
    rcp_q       <= rcp_d;
    dcnt_q      <= dcnt_d;
    neg_q       <= neg_d;
    num_q       <= num_d;
    qe_q        <= qe_d;
    sat_q       <= sat_d;
    prod2_q     <= prod2_d;
    tap_value_q <= tap_value_d;
    tap_index_q <= tap_index_d;
    last_tap_q  <= last_tap_d;
  end

  assign out_valid_o = out_valid_q;
  assign tap_value_o = tap_value_q;
  assign tap_index_o = tap_index_q;
  assign last_tap_o  = last_tap_q;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rrc_tap_generator
// Sends half lengths (directed corners, then random ones), predicts every
// normalized tap and compares each output transfer field by field, with
// random valid gaps and output stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

  import rrc_pkg::*;

  localparam int          CLK_HALF    = 2;
  localparam int          RESET_LEN   = 7;
  localparam int          RANDOM_LENS = 139;
  localparam int          IDLE_PCT    = 12;
  localparam int          DRAIN_LEN   = 64;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  // Q2.14 prototype, offset from center in half symbols
  localparam int PROTO_LEN = 17;
  localparam int PROTO_Q214 [PROTO_LEN] = '{
    17167, 10311, -760, -3129, 694, 1539, -592, -788, 468,
    355, -335, -99, 209, -41, -100, 100, 17
  };

  typedef struct {
    logic signed [TAP_BITS-1:0] value;
    logic [IDX_W-1:0]           index;
    logic                       last;
  } tap_rec_t;

  class tap_board;
    tap_rec_t    expected_taps[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int pending();
      return expected_taps.size();
    endfunction

    // predict the full filter for one accepted half length
    function void note_length(logic [HL_W-1:0] half_len);
      int       n;
      int       center;
      int       k;
      int       total;
      int       taps [2*MAX_HALF];
      longint   sum;
      longint   divisor;
      longint   mag;
      longint   quot;
      tap_rec_t rec;
      n = half_len;
      if (n < 1) n = 1;
      if (n > MAX_HALF) n = MAX_HALF;
      total = 2 * n;
      foreach (taps[i]) taps[i] = 0;
      center = (n + 2) / 2 - 1;
      // right side from the center, mirrored to the left; for odd n the
      // mirror of the first off-center value lands on the center itself
      for (int pos = center; pos <= n; pos++) begin
        k = pos - center;
        if (k >= PROTO_LEN) break;
        taps[pos] = PROTO_Q214[k];
        if (k > 0) taps[n - pos] = PROTO_Q214[k];
      end
      sum = 0;
      for (int i = 0; i < total; i++) sum += taps[i];
      divisor = (sum > 0) ? sum : 1;
      for (int i = 0; i < total; i++) begin
        mag  = (taps[i] < 0) ? -longint'(taps[i]) : longint'(taps[i]);
        quot = ((mag <<< FRAC) + divisor / 2) / divisor;
        if (taps[i] < 0) begin
          if (quot > (longint'(1) <<< FRAC)) quot = longint'(1) <<< FRAC;
          rec.value = TAP_BITS'(-quot);
        end else begin
          if (quot > (longint'(1) <<< FRAC) - 1) quot = (longint'(1) <<< FRAC) - 1;
          rec.value = TAP_BITS'(quot);
        end
        rec.index = IDX_W'(i);
        rec.last  = (i == total - 1);
        expected_taps.push_back(rec);
      end
    endfunction

    function void check_tap(logic signed [TAP_BITS-1:0] value, logic [IDX_W-1:0] index,
                            logic last);
      tap_rec_t want;
      if (expected_taps.size() == 0) begin
        $error("unexpected tap transfer: value %0d index %0d last %0b", value, index, last);
        mismatches++;
        return;
      end
      want = expected_taps.pop_front();
      if (value !== want.value) begin
        $error("tap_value: expected %0d, got %0d", want.value, value);
        mismatches++;
      end
      if (index !== want.index) begin
        $error("tap_index: expected %0d, got %0d", want.index, index);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last_tap: expected %0b, got %0b", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       in_valid_i    = 1'b0;
  logic                       in_stall_o;
  logic [HL_W-1:0]            half_length_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i   = 1'b0;
  logic signed [TAP_BITS-1:0] tap_value_o;
  logic [IDX_W-1:0]           tap_index_o;
  logic                       last_tap_o;

  tap_board    board = new();
  bit          calm  = 1'b0;
  int unsigned cycles = 0;

  rrc_tap_generator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .half_length_i (half_length_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .tap_value_o   (tap_value_o),
    .tap_index_o   (tap_index_o),
    .last_tap_o    (last_tap_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // output side: check each transfer, stall at random outside the calm stretch
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        board.check_tap(tap_value_o, tap_index_o, last_tap_o);
      end
      out_stall_i <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // one input transfer, with random idle cycles ahead of it
  task automatic send_length(input logic [HL_W-1:0] half_len);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    half_length_i <= half_len;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_length(half_len);
  endtask

  task automatic drain_taps();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // mostly legal lengths, some zero and some above the maximum
  function automatic logic [HL_W-1:0] pick_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return '0;
    if (roll < 18) return HL_W'($urandom_range(MAX_HALF + 1, 2**HL_W - 1));
    return HL_W'($urandom_range(1, MAX_HALF));
  endfunction

  initial begin
    logic [HL_W-1:0] corner_lens [$];
    corner_lens = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 15, 16, 17, 18, 30, 31, 32, 33, 34,
                    42, 62, 63};
    repeat (RESET_LEN) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners: zero, odd and even, the maximum and beyond it
    foreach (corner_lens[i]) send_length(corner_lens[i]);
    // hold off until the whole backlog is out
    drain_taps();

    for (int i = 0; i < RANDOM_LENS; i++) begin
      calm = (i >= 60) && (i < 100);
      send_length(pick_length());
      if (i == 120) drain_taps();
    end
    calm = 1'b0;

    drain_taps();
    repeat (DRAIN_LEN) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- rrc_tap_generator.f -----
src/rrc_pkg.sv
src/rrc_tap_generator.sv
test/testbench.sv
